### hw/rtl/kxs_pkg.sv
// Shared types and constants for the keyed XOR bit-shift scrambler.
package kxs_pkg;

    localparam int KEY_BYTES   = 16;
    localparam int KEY_POS_W   = 5;
    localparam int CARRY_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CARRY_W-1:0]   CARRY_MARKER = 5'd3;
    localparam logic [KEY_POS_W-1:0] KEY_LIMIT    = KEY_POS_W'(KEY_BYTES);

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd3;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef struct packed {
        logic                  direction;
        logic [KEY_POS_W-1:0]  key_length;
        logic [63:0]           key_low;
        logic [63:0]           key_high;
    } t_cfg;

    typedef struct packed {
        logic [KEY_POS_W-1:0]  key_pos;
        logic [CARRY_W-1:0]    carry;
        logic                  have_prev;
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [7:0]  head_byte;
        logic        head_last;
        logic        extra_valid;
        logic [7:0]  extra_byte;
    } t_push;

    localparam t_state STATE_RESET = '{key_pos: '0, carry: CARRY_MARKER, have_prev: 1'b0};

endpackage

### hw/rtl/keyed_xor_bit_shift_scrambler_core.sv
// Top level of the keyed XOR bit-shift scrambler: input register, message state, result stage.
// An item held in the input register has its first result loaded into the result register
// once the result stage has room.
// Throughput: one item per cycle while the result stage has room; an encrypt item marked last
// holds back the next item while its spilled byte waits in the result register's second slot.
// Reset: synchronous, active low; clears the configuration to encrypt, key length 1, zero key,
// and the message state to cursor 0, marker carry 3, no previous byte. No clearing pass.
module keyed_xor_bit_shift_scrambler_core
    import kxs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       cfg;
    t_state     r_state;
    t_state     step_state;
    t_push      step_push;
    t_push      push;
    logic       r_iv;
    logic [7:0] r_data;
    logic       r_last;
    logic       out_free;
    logic       fire;

    kxs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kxs_step u_step (
        .i_cfg       (cfg),
        .i_state     (r_state),
        .i_data_byte (r_data),
        .i_last_byte (r_last),
        .o_state     (step_state),
        .o_push      (step_push)
    );

    // advance the held item once the result stage has room
    assign fire       = r_iv && out_free;
    assign o_in_ready = !r_iv || fire;

    always_comb begin
        push       = step_push;
        push.valid = fire && step_push.valid;
    end

    kxs_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv    <= 1'b0;
            r_state <= STATE_RESET;
        end else begin
            if (o_in_ready) begin
                r_iv <= i_in_valid;
            end
            if (fire) begin
                r_state <= step_state;
            end
        end
        if (o_in_ready && i_in_valid) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

endmodule

### hw/rtl/kxs_cfg_regs.sv
// Configuration register file for the scrambler.
module kxs_cfg_regs
    import kxs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction  <= DIR_ENCRYPT;
            r_cfg.key_length <= KEY_POS_W'(1);
            r_cfg.key_low    <= '0;
            r_cfg.key_high   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIRECTION:  r_cfg.direction  <= i_cfg_data[0];
                CFG_KEY_LENGTH: r_cfg.key_length <= i_cfg_data[KEY_POS_W-1:0];
                CFG_KEY_LOW:    r_cfg.key_low    <= i_cfg_data;
                CFG_KEY_HIGH:   r_cfg.key_high   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

### hw/rtl/kxs_key_cursor.sv
// Key cursor: picks the current key byte and the cursor's next position.
module kxs_key_cursor
    import kxs_pkg::*;
(
    input  t_cfg                  i_cfg,
    input  logic [KEY_POS_W-1:0]  i_pos,
    output logic [7:0]            o_key,
    output logic [KEY_POS_W-1:0]  o_next_pos
);

    logic [KEY_POS_W-1:0] len;
    logic                 wrap;
    logic [3:0]           idx;
    logic [127:0]         keys;

    always_comb begin
        len        = (i_cfg.key_length > KEY_LIMIT) ? KEY_LIMIT : i_cfg.key_length;
        // on wrap, hand out key byte 0 and park the cursor at 0 without advancing
        wrap       = (i_pos >= len);
        idx        = wrap ? 4'd0 : i_pos[3:0];
        keys       = {i_cfg.key_high, i_cfg.key_low};
        o_key      = keys[{3'b000, idx} * 7'd8 +: 8];
        o_next_pos = wrap ? '0 : i_pos + KEY_POS_W'(1);
    end

endmodule

### hw/rtl/kxs_step.sv
// Per-item transform: key XOR, 5-bit shift across bytes, next message state.
module kxs_step
    import kxs_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_state      i_state,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output t_state      o_state,
    output t_push       o_push
);

    logic [7:0]           key;
    logic [KEY_POS_W-1:0] cursor_next;
    logic [7:0]           x;
    logic [7:0]           y;
    logic                 use_key;
    t_state               n_state;

    kxs_key_cursor u_cursor (
        .i_cfg      (i_cfg),
        .i_pos      (i_state.key_pos),
        .o_key      (key),
        .o_next_pos (cursor_next)
    );

    always_comb begin
        x = i_data_byte ^ key;
        // decrypt: previous top 3 bits low, current low 5 bits on top
        y = {i_data_byte[4:0], i_state.carry[2:0]} ^ key;
        use_key = (i_cfg.direction == DIR_ENCRYPT) || i_state.have_prev;

        n_state.key_pos   = use_key ? cursor_next : i_state.key_pos;
        n_state.have_prev = 1'b1;
        if (i_cfg.direction == DIR_ENCRYPT) begin
            n_state.carry = x[7:3];
        end else begin
            n_state.carry = {2'b00, i_data_byte[7:5]};
        end
        o_state = i_last_byte ? STATE_RESET : n_state;

        o_push.valid       = use_key;
        o_push.extra_byte  = {3'b000, x[7:3]};
        if (i_cfg.direction == DIR_ENCRYPT) begin
            o_push.head_byte   = {x[2:0], i_state.carry};
            o_push.head_last   = 1'b0;
            o_push.extra_valid = i_last_byte;
        end else begin
            o_push.head_byte   = y;
            o_push.head_last   = i_last_byte;
            o_push.extra_valid = 1'b0;
        end
    end

endmodule

### hw/rtl/kxs_out_stage.sv
// Result register with one extra slot for the spilled final byte.
module kxs_out_stage
    import kxs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_free,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last
);

    logic       r_ov;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       r_xv;
    logic [7:0] r_xbyte;
    logic       n_ov;
    logic [7:0] n_obyte;
    logic       n_olast;
    logic       n_xv;
    logic [7:0] n_xbyte;

    // free only when no extra byte waits and the head slot is empty or empties this cycle
    assign o_free      = !r_xv && (!r_ov || i_out_ready);
    assign o_out_valid = r_ov;
    assign o_out_byte  = r_obyte;
    assign o_out_last  = r_olast;

    always_comb begin
        n_ov    = r_ov;
        n_obyte = r_obyte;
        n_olast = r_olast;
        n_xv    = r_xv;
        n_xbyte = r_xbyte;
        if (r_ov && i_out_ready) begin
            // promote the spilled byte, or drop the head
            n_ov    = r_xv;
            n_obyte = r_xbyte;
            n_olast = 1'b1;
            n_xv    = 1'b0;
        end
        if (i_push.valid) begin
            n_ov    = 1'b1;
            n_obyte = i_push.head_byte;
            n_olast = i_push.head_last;
            n_xv    = i_push.extra_valid;
            n_xbyte = i_push.extra_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_xv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_xv <= n_xv;
        end
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_xbyte <= n_xbyte;
    end

    a_extra_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_xv |-> r_ov)
        else $error("extra byte held without a head byte");

    a_push_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> o_free)
        else $error("result pushed while the output stage is full");

    a_extra_promoted_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_xv && i_out_ready) |=> (r_ov && r_olast && !r_xv))
        else $error("spilled byte not presented as the final item");

endmodule

### tb/keyed_xor_bit_shift_scrambler_core_tb.sv
// Self-checking testbench for the keyed XOR bit-shift scrambler core.
module keyed_xor_bit_shift_scrambler_core_tb;
    import kxs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PAUSE  = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte = '0;
    logic                  i_last_byte = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_out_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // register copy kept by the predictor
    logic                 cfg_dir      = DIR_ENCRYPT;
    logic [KEY_POS_W-1:0] cfg_key_len  = 5'd1;
    logic [63:0]          cfg_key_low  = '0;
    logic [63:0]          cfg_key_high = '0;

    // message state kept by the predictor
    logic [KEY_POS_W-1:0] msg_key_pos   = '0;
    logic [CARRY_W-1:0]   msg_carry     = CARRY_MARKER;
    logic                 msg_have_prev = 1'b0;

    byte_item_t msg_byte_q[$];
    byte_item_t scrambled_q[$];

    int bytes_queued   = 0;
    int bytes_taken    = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    keyed_xor_bit_shift_scrambler_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Key cursor: on reaching the length, hand out key byte 0 and restart without advancing.
    function automatic logic [7:0] next_key_byte();
        logic [KEY_POS_W-1:0] span;
        logic [127:0]         key_bytes;
        logic [7:0]           k;
        key_bytes = {cfg_key_high, cfg_key_low};
        span = (cfg_key_len > KEY_LIMIT) ? KEY_LIMIT : cfg_key_len;
        if (msg_key_pos >= span) begin
            msg_key_pos = '0;
            k = key_bytes[7:0];
        end else begin
            k = key_bytes[msg_key_pos[3:0]*8 +: 8];
            msg_key_pos = msg_key_pos + 1'b1;
        end
        return k;
    endfunction

    task automatic scramble_byte(input logic [7:0] d, input logic last);
        logic [7:0] x;
        if (cfg_dir == DIR_ENCRYPT) begin
            x = d ^ next_key_byte();
            scrambled_q.push_back('{data: {x[2:0], msg_carry}, last: 1'b0});
            msg_carry = x[7:3];
            msg_have_prev = 1'b1;
            // spilled top bits leave as an extra closing byte
            if (last)
                scrambled_q.push_back('{data: {3'b000, msg_carry}, last: 1'b1});
        end else begin
            if (msg_have_prev) begin
                x = {d[4:0], msg_carry[2:0]} ^ next_key_byte();
                scrambled_q.push_back('{data: x, last: last});
            end
            msg_carry = {2'b00, d[7:5]};
            msg_have_prev = 1'b1;
        end
        if (last) begin
            msg_key_pos = '0;
            msg_carry = CARRY_MARKER;
            msg_have_prev = 1'b0;
        end
    endtask

    // Sender: hold the item until accepted, then maybe idle before the next one.
    always @(posedge i_clk) begin : feed_proc
        byte_item_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                scramble_byte(i_data_byte, i_last_byte);
                bytes_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (msg_byte_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    nxt = msg_byte_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_last_byte <= nxt.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted item against the oldest prediction.
    always @(posedge i_clk) begin : check_proc
        byte_item_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (scrambled_q.size() == 0) begin
                    $error("unexpected item: out_byte %02h out_last %0b", o_out_byte, o_out_last);
                    fail_count++;
                end else begin
                    want = scrambled_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                        fail_count++;
                    end
                    if (o_out_last !== want.last) begin
                        $error("out_last: expected %0b, got %0b", want.last, o_out_last);
                        fail_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic last);
        msg_byte_q.push_back('{data: d, last: last});
        bytes_queued++;
    endtask

    task automatic send_msg(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom), i == n - 1);
    endtask

    // Wait until every item is taken and every prediction met, then let the pipe settle.
    task automatic wait_idle();
        @(posedge i_clk);
        while (bytes_taken != bytes_queued || scrambled_q.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DIRECTION:  cfg_dir = val[0];
            CFG_KEY_LENGTH: cfg_key_len = val[KEY_POS_W-1:0];
            CFG_KEY_LOW:    cfg_key_low = val;
            CFG_KEY_HIGH:   cfg_key_high = val;
            default: ;
        endcase
    endtask

    function automatic logic [63:0] pick_key();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic randomize_cfg();
        logic [63:0] len_word;
        len_word = {$urandom, $urandom};
        case ($urandom_range(5))
            0:       len_word[4:0] = 5'd0;
            1:       len_word[4:0] = 5'd1;
            2:       len_word[4:0] = 5'd16;
            3:       len_word[4:0] = 5'd31;
            default: len_word[4:0] = 5'($urandom_range(2, 15));
        endcase
        write_reg(CFG_DIRECTION, {$urandom, $urandom});
        write_reg(CFG_KEY_LENGTH, len_word);
        write_reg(CFG_KEY_LOW, pick_key());
        write_reg(CFG_KEY_HIGH, pick_key());
    endtask

    initial begin
        int sent;
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full key, encrypt: field extremes and a one-byte message
        write_reg(CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
        write_reg(CFG_KEY_LENGTH, 64'd16);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hA5, 1'b1);
        push_byte(8'hFF, 1'b1);

        // decrypt: a one-byte message yields nothing
        wait_idle();
        write_reg(CFG_DIRECTION, 64'(DIR_DECRYPT));
        push_byte(8'h5A, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h81, 1'b1);

        // zero key length always uses key byte 0
        wait_idle();
        write_reg(CFG_KEY_LENGTH, 64'd0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);

        // short key wraps inside the message
        wait_idle();
        write_reg(CFG_KEY_LENGTH, 64'd3);
        write_reg(CFG_DIRECTION, 64'(DIR_ENCRYPT));
        push_byte(8'hC3, 1'b0);
        push_byte(8'h3C, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hAA, 1'b1);

        // length above the key size clamps
        wait_idle();
        write_reg(CFG_KEY_LENGTH, 64'd31);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b1);

        // shrink the key length mid-message so the cursor lies beyond it
        wait_idle();
        write_reg(CFG_KEY_LENGTH, 64'd16);
        send_msg(4);
        msg_byte_q[$].last = 1'b0;
        wait_idle();
        write_reg(CFG_KEY_LENGTH, 64'd2);
        push_byte(8'h69, 1'b1);

        // flip direction mid-message with the carry held
        wait_idle();
        push_byte(8'hE7, 1'b0);
        push_byte(8'h18, 1'b0);
        wait_idle();
        write_reg(CFG_DIRECTION, 64'(DIR_DECRYPT));
        push_byte(8'hB4, 1'b0);
        push_byte(8'h4B, 1'b1);

        for (int p = 0; p < 4; p++) begin
            wait_idle();
            case (p)
                0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_gap_pct = 83; recv_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  recv_stall_pct = 83; end
                default: begin send_gap_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int s = 0; s < 4; s++) begin
                wait_idle();
                randomize_cfg();
                sent = 0;
                while (sent < 37) begin
                    // mostly short messages, some long enough to wrap a full key
                    n = ($urandom_range(99) < 80) ? $urandom_range(1, 12)
                                                  : $urandom_range(13, 40);
                    send_msg(n);
                    sent += n;
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && scrambled_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/kxs_pkg.sv
hw/rtl/kxs_cfg_regs.sv
hw/rtl/kxs_key_cursor.sv
hw/rtl/kxs_step.sv
hw/rtl/kxs_out_stage.sv
hw/rtl/keyed_xor_bit_shift_scrambler_core.sv
tb/keyed_xor_bit_shift_scrambler_core_tb.sv
